// File: rtl/cpe_pkg.sv
// shared constants and types for the cell porosity erosion update unit
// no dependencies
`default_nettype none
package cpe_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int REG_IDX_W     = 3;
  localparam int SQ_W          = 64;
  localparam int DIV_W         = 64;

  localparam logic signed [63:0] T48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] T48_MIN = -64'sh0000_8000_0000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SPEED_THRESHOLD = 3'd0,
    REG_EROSION_RATE    = 3'd1,
    REG_DEPOSITION_RATE = 3'd2,
    REG_SOLID_DENSITY   = 3'd3,
    REG_TIME_STEP       = 3'd4,
    REG_TIME_SCALE      = 3'd5,
    REG_WELL_POROSITY   = 3'd6
  } reg_idx_t;

endpackage
`default_nettype wire

// File: rtl/cpe_sqrt.sv
// pipelined floor square root, one result bit per stage
// depends on cpe_pkg
`default_nettype none
module cpe_sqrt #(
  parameter int TAG_W = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [cpe_pkg::SQ_W-1:0]  radicand,
  input  wire logic [TAG_W-1:0]          in_tag,
  output logic                           out_valid,
  output logic [cpe_pkg::SQ_W/2-1:0]     root,
  output logic [TAG_W-1:0]               out_tag
);

  localparam int W     = cpe_pkg::SQ_W;
  localparam int STEPS = W / 2;

  logic [W-1:0]     rem   [STEPS+1];
  logic [W-1:0]     res   [STEPS+1];
  logic [TAG_W-1:0] tag   [STEPS+1];
  logic             valid [STEPS+1];

  assign rem[0]   = radicand;
  assign res[0]   = '0;
  assign tag[0]   = in_tag;
  assign valid[0] = in_valid;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * g);
    logic [W-1:0] trial;
    logic         ge;

    always_comb begin
      trial = res[g] + BIT;
      ge    = rem[g] >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[g+1] <= 1'b0;
      end else if (en) begin
        valid[g+1] <= valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= ge ? rem[g] - trial : rem[g];
        res[g+1] <= ge ? (res[g] >> 1) + BIT : res[g] >> 1;
        tag[g+1] <= tag[g];
      end
    end
  end

  assign out_valid = valid[STEPS];
  assign root      = res[STEPS][STEPS-1:0];
  assign out_tag   = tag[STEPS];

endmodule
`default_nettype wire

// File: rtl/cpe_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on cpe_pkg
`default_nettype none
module cpe_div #(
  parameter int TAG_W = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [cpe_pkg::DIV_W-1:0]  numer,
  input  wire logic [cpe_pkg::DIV_W-1:0]  denom,
  input  wire logic [TAG_W-1:0]           in_tag,
  output logic                            out_valid,
  output logic [cpe_pkg::DIV_W-1:0]       quot,
  output logic [TAG_W-1:0]                out_tag
);

  localparam int W = cpe_pkg::DIV_W;

  // quotient bits shift into the low end of the numerator word
  logic [W-1:0]     rem   [W+1];
  logic [W-1:0]     num   [W+1];
  logic [W-1:0]     den   [W+1];
  logic [TAG_W-1:0] tag   [W+1];
  logic             valid [W+1];

  assign rem[0]   = '0;
  assign num[0]   = numer;
  assign den[0]   = denom;
  assign tag[0]   = in_tag;
  assign valid[0] = in_valid;

  for (genvar g = 0; g < W; g++) begin : g_step
    logic [W:0] shifted;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
      shifted = {rem[g], num[g][W-1]};
      diff    = shifted - {1'b0, den[g]};
      ge      = shifted >= {1'b0, den[g]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[g+1] <= 1'b0;
      end else if (en) begin
        valid[g+1] <= valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= ge ? diff[W-1:0] : shifted[W-1:0];
        num[g+1] <= {num[g][W-2:0], ge};
        den[g+1] <= den[g];
        tag[g+1] <= tag[g];
      end
    end
  end

  assign out_valid = valid[W];
  assign quot      = num[W];
  assign out_tag   = tag[W];

endmodule
`default_nettype wire

// File: rtl/cell_porosity_erosion_update_unit.sv
// top level of the cell porosity erosion update unit
// depends on cpe_pkg, cpe_sqrt and cpe_div
//
//  channel   signals                                   direction
//  input     in_valid, in_stall, flux_*, concentration, porosity_in,
//            dilatation_rate, well_cell                into the block
//  output    out_valid, out_stall, new_source, source_written,
//            new_porosity                              out of the block
//  config    wr_en, wr_index, wr_data                  into the block
//
// one word accepted per cycle while the output is not stalled; the pipeline holds 4 front stages,
// 32 square root stages, 3 product stages, 64 divider stages, 5 back stages
// and the output register. the divider stages are the deepest part.
// rst clears valid bits and loads register reset values.
// a stall at the output while a word waits freezes the whole pipeline.
`default_nettype none
module cell_porosity_erosion_update_unit #(
  parameter int FRAC_BITS = cpe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [cpe_pkg::REG_IDX_W-1:0]   wr_index,
  input  wire logic [cpe_pkg::WORD_W-1:0]      wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [31:0]              flux_west,
  input  wire logic signed [31:0]              flux_south,
  input  wire logic signed [31:0]              flux_bottom,
  input  wire logic signed [31:0]              flux_east,
  input  wire logic signed [31:0]              flux_north,
  input  wire logic signed [31:0]              flux_top,
  input  wire logic signed [31:0]              concentration,
  input  wire logic signed [31:0]              porosity_in,
  input  wire logic signed [31:0]              dilatation_rate,
  input  wire logic                            well_cell,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [31:0]                   new_source,
  output logic                                 source_written,
  output logic signed [31:0]                   new_porosity
);

  localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [32:0] ONE33 = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] LIM   = 32'((7 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  typedef struct packed {
    logic signed [31:0] por;
    logic signed [31:0] conc;
    logic signed [31:0] dil;
    logic               well;
  } side_t;

  typedef struct packed {
    logic q_neg;
    logic den_zero;
    logic num_zero;
    logic num_neg;
  } div_flags_t;

  typedef struct packed {
    side_t              side;
    logic signed [47:0] t1;
    div_flags_t         f2;
  } div_tag_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    if (x > cpe_pkg::T48_MAX) return cpe_pkg::T48_MAX[47:0];
    else if (x < cpe_pkg::T48_MIN) return cpe_pkg::T48_MIN[47:0];
    else return x[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'h7FFF_FFFF;
    else if (x < -66'sd2147483648) return 32'h8000_0000;
    else return x[31:0];
  endfunction

  // sign, saturation and zero divisor fix-up of a quotient magnitude
  function automatic logic signed [47:0] div_fix(input logic [63:0] q,
                                                 input div_flags_t f);
    if (f.den_zero) begin
      if (f.num_zero) return '0;
      else if (f.num_neg) return cpe_pkg::T48_MIN[47:0];
      else return cpe_pkg::T48_MAX[47:0];
    end else if (f.q_neg) begin
      if (q > 64'h0000_8000_0000_0000) return cpe_pkg::T48_MIN[47:0];
      else return 48'(~q + 64'd1);
    end else begin
      if (q > 64'h0000_7FFF_FFFF_FFFF) return cpe_pkg::T48_MAX[47:0];
      else return q[47:0];
    end
  endfunction

  // configuration registers
  logic signed [31:0] speed_threshold, erosion_rate, deposition_rate, solid_density;
  logic signed [31:0] time_step, time_scale, well_porosity;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_threshold <= '0;
      erosion_rate    <= '0;
      deposition_rate <= '0;
      solid_density   <= ONE32;
      time_step       <= '0;
      time_scale      <= ONE32;
      well_porosity   <= '0;
    end else if (wr_en) begin
      case (cpe_pkg::reg_idx_t'(wr_index))
        cpe_pkg::REG_SPEED_THRESHOLD: speed_threshold <= wr_data;
        cpe_pkg::REG_EROSION_RATE:    erosion_rate    <= wr_data;
        cpe_pkg::REG_DEPOSITION_RATE: deposition_rate <= wr_data;
        cpe_pkg::REG_SOLID_DENSITY:   solid_density   <= wr_data;
        cpe_pkg::REG_TIME_STEP:       time_step       <= wr_data;
        cpe_pkg::REG_TIME_SCALE:      time_scale      <= wr_data;
        cpe_pkg::REG_WELL_POROSITY:   well_porosity   <= wr_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // front: abs, squares, pair sums, total
  logic signed [31:0] flux [6];
  assign flux[0] = flux_west;
  assign flux[1] = flux_south;
  assign flux[2] = flux_bottom;
  assign flux[3] = flux_east;
  assign flux[4] = flux_north;
  assign flux[5] = flux_top;

  logic        v1, v2, v3, v4;
  side_t       s1_side, s2_side, s3_side, s4_side;
  logic [31:0] s1_abs [6];
  logic [63:0] s2_sq  [6];
  logic [64:0] s3_pair [3];
  logic [63:0] s4_sum;
  logic [66:0] total;

  always_comb begin
    total = 67'(s3_pair[0]) + 67'(s3_pair[1]) + 67'(s3_pair[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        s1_abs[i] <= flux[i][31] ? 32'(-flux[i]) : 32'(flux[i]);
        s2_sq[i]  <= 64'(s1_abs[i]) * 64'(s1_abs[i]);
      end
      for (int j = 0; j < 3; j++) begin
        s3_pair[j] <= {1'b0, s2_sq[2*j]} + {1'b0, s2_sq[2*j+1]};
      end
      s4_sum  <= (total[66:64] != 3'b000) ? '1 : total[63:0];
      s1_side <= '{por: porosity_in, conc: concentration, dil: dilatation_rate,
                   well: well_cell};
      s2_side <= s1_side;
      s3_side <= s2_side;
      s4_side <= s3_side;
    end
  end

  // square root
  logic        vq;
  logic [31:0] root;
  logic [$bits(side_t)-1:0] sq_tag;
  side_t       q_side;

  cpe_sqrt #(.TAG_W($bits(side_t))) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v4), .radicand(s4_sum), .in_tag(s4_side),
    .out_valid(vq), .root(root), .out_tag(sq_tag)
  );
  assign q_side = side_t'(sq_tag);

  // speed, tear-off, products, divider operands
  logic               v5, v6, v7;
  side_t              s5_side, s6_side, s7_side;
  logic signed [31:0] s5_speed, s5_tear;
  logic signed [31:0] speed_sat;
  logic signed [63:0] s6_num2, s6_pden, s6_pt1, s6_num3;
  logic signed [63:0] den2;
  logic [63:0]        s7_num2, s7_den2, s7_num3, s7_den3;
  logic signed [47:0] s7_t1;
  div_flags_t         s7_f2, s7_f3;

  always_comb begin
    speed_sat = root[31] ? 32'sh7FFF_FFFF : $signed(root);
    den2      = s6_pden >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v5 <= vq;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side  <= q_side;
      s5_speed <= speed_sat;
      s5_tear  <= (33'(speed_sat) < 33'(speed_threshold)) ? '0 : erosion_rate;

      s6_side  <= s5_side;
      s6_num2  <= 64'(s5_tear) * 64'(s5_speed);
      s6_pden  <= 64'(s5_side.por) * 64'(solid_density);
      s6_pt1   <= 64'(deposition_rate) * 64'(s5_side.conc);
      s6_num3  <= 64'(s5_tear) * 64'(speed_threshold);

      s7_side  <= s6_side;
      s7_t1    <= sat48(s6_pt1 >>> FRAC_BITS);
      s7_num2  <= mag64(s6_num2);
      s7_den2  <= mag64(den2);
      s7_num3  <= mag64(s6_num3);
      s7_den3  <= mag64(64'(solid_density));
      s7_f2    <= '{q_neg: s6_num2[63] ^ den2[63], den_zero: den2 == '0,
                    num_zero: s6_num2 == '0, num_neg: s6_num2[63]};
      s7_f3    <= '{q_neg: s6_num3[63] ^ solid_density[31],
                    den_zero: solid_density == '0,
                    num_zero: s6_num3 == '0, num_neg: s6_num3[63]};
    end
  end

  // dividers
  logic        vd;
  logic [63:0] quot2, quot3;
  logic [$bits(div_tag_t)-1:0]   d2_tag_raw;
  logic [$bits(div_flags_t)-1:0] d3_tag_raw;
  div_tag_t    d2_tag;
  div_flags_t  d3_flags;

  cpe_div #(.TAG_W($bits(div_tag_t))) u_div_por (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v7), .numer(s7_num2), .denom(s7_den2),
    .in_tag({s7_side, s7_t1, s7_f2}),
    .out_valid(vd), .quot(quot2), .out_tag(d2_tag_raw)
  );

  cpe_div #(.TAG_W($bits(div_flags_t))) u_div_rho (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v7), .numer(s7_num3), .denom(s7_den3),
    .in_tag(s7_f3),
    .out_valid(), .quot(quot3), .out_tag(d3_tag_raw)
  );

  assign d2_tag   = div_tag_t'(d2_tag_raw);
  assign d3_flags = div_flags_t'(d3_tag_raw);

  // back: source, porosity rate, update
  logic               v8, v9, v10, v11, v12;
  side_t              s8_side, s9_side, s10_side, s11_side, s12_side;
  logic signed [47:0] s8_t1, s8_t2, s8_t3;
  logic signed [31:0] s9_src, s10_src, s11_src, s12_src;
  logic signed [64:0] s10_pa;
  logic signed [63:0] s10_pb;
  logic signed [31:0] s11_rate;
  logic signed [63:0] s12_pc;
  logic signed [31:0] np_sat, np_lim;

  always_comb begin
    np_sat = sat32(66'(s12_side.por) + 66'(s12_pc >>> FRAC_BITS));
    np_lim = (np_sat > LIM) ? LIM : np_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8        <= 1'b0;
      v9        <= 1'b0;
      v10       <= 1'b0;
      v11       <= 1'b0;
      v12       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v8        <= vd;
      v9        <= v8;
      v10       <= v9;
      v11       <= v10;
      v12       <= v11;
      out_valid <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_side  <= d2_tag.side;
      s8_t1    <= d2_tag.t1;
      s8_t2    <= div_fix(quot2, d2_tag.f2);
      s8_t3    <= div_fix(quot3, d3_flags);

      s9_side  <= s8_side;
      s9_src   <= sat32(66'(s8_t1) - 66'(s8_t2) + 66'(s8_t3));

      s10_side <= s9_side;
      s10_src  <= s9_src;
      s10_pa   <= 65'(ONE33 - 33'(s9_side.por)) * 65'(s9_side.dil);
      s10_pb   <= 64'(time_scale) * 64'(s9_src);

      s11_side <= s10_side;
      s11_src  <= s10_src;
      s11_rate <= sat32(66'(s10_pa >>> FRAC_BITS) - 66'(s10_pb >>> FRAC_BITS));

      s12_side <= s11_side;
      s12_src  <= s11_src;
      s12_pc   <= 64'(time_step) * 64'(s11_rate);

      // well cells take the fixed porosity and give no source
      new_source     <= s12_side.well ? '0 : s12_src;
      source_written <= !s12_side.well;
      new_porosity   <= s12_side.well ? well_porosity : np_lim;
    end
  end

endmodule
`default_nettype wire

// File: dv/cpe_checker.sv
// checker for the cell porosity erosion update unit: predicts each cell's source and porosity
// from its own register copy and compares the output words in order; depends on cpe_pkg
`timescale 1ns / 1ps
module cpe_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [cpe_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [cpe_pkg::WORD_W-1:0]    wr_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic signed [31:0]            flux_west,
  input  wire logic signed [31:0]            flux_south,
  input  wire logic signed [31:0]            flux_bottom,
  input  wire logic signed [31:0]            flux_east,
  input  wire logic signed [31:0]            flux_north,
  input  wire logic signed [31:0]            flux_top,
  input  wire logic signed [31:0]            concentration,
  input  wire logic signed [31:0]            porosity_in,
  input  wire logic signed [31:0]            dilatation_rate,
  input  wire logic                          well_cell,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic signed [31:0]            new_source,
  input  wire logic                          source_written,
  input  wire logic signed [31:0]            new_porosity,
  output int                                 errors,
  output int                                 pending
);

  localparam int FB = 16;
  localparam longint ONE = longint'(1) << FB;
  localparam longint POR_LIM = (7 * ONE + 5) / 10;
  localparam longint I32_MAX = 64'sh7FFF_FFFF;
  localparam longint I32_MIN = -64'sh8000_0000;

  typedef struct {
    logic signed [31:0] src;
    logic               written;
    logic signed [31:0] por;
  } cell_update_t;

  longint       regs [7];
  cell_update_t updates_due [$];

  function automatic longint sat(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint div_clip(longint n, longint d);
    if (d == 0) return n > 0 ? 64'sh7FFF_FFFF_FFFF_FFFF : (n < 0 ? 64'sh8000_0000_0000_0000 : 0);
    return n / d;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic cell_update_t predict_cell(longint f [6], longint conc, longint por,
                                                longint dil, logic well);
    cell_update_t u;
    logic [64:0] acc;
    longint unsigned sum, mag;
    longint speed, tear, t1, t2, t3, src, rate, np;
    if (well) begin
      u.src = 0;
      u.written = 1'b0;
      u.por = regs[cpe_pkg::REG_WELL_POROSITY][31:0];
      return u;
    end
    sum = 0;
    foreach (f[i]) begin
      mag = f[i] < 0 ? -f[i] : f[i];
      acc = {1'b0, sum} + {1'b0, mag * mag};
      sum = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
    end
    speed = longint'(root64(sum));
    if (speed > I32_MAX) speed = I32_MAX;
    tear = (speed < regs[cpe_pkg::REG_SPEED_THRESHOLD]) ? 0 : regs[cpe_pkg::REG_EROSION_RATE];
    t1 = sat((regs[cpe_pkg::REG_DEPOSITION_RATE] * conc) >>> FB,
             cpe_pkg::T48_MIN, cpe_pkg::T48_MAX);
    t2 = sat(div_clip(tear * speed, (por * regs[cpe_pkg::REG_SOLID_DENSITY]) >>> FB),
             cpe_pkg::T48_MIN, cpe_pkg::T48_MAX);
    t3 = sat(div_clip(tear * regs[cpe_pkg::REG_SPEED_THRESHOLD],
                      regs[cpe_pkg::REG_SOLID_DENSITY]),
             cpe_pkg::T48_MIN, cpe_pkg::T48_MAX);
    src = sat(t1 - t2 + t3, I32_MIN, I32_MAX);
    rate = (((ONE - por) * dil) >>> FB) - ((regs[cpe_pkg::REG_TIME_SCALE] * src) >>> FB);
    rate = sat(rate, I32_MIN, I32_MAX);
    np = sat(por + ((regs[cpe_pkg::REG_TIME_STEP] * rate) >>> FB), I32_MIN, I32_MAX);
    if (np > POR_LIM) np = POR_LIM;
    u.src = src[31:0];
    u.written = 1'b1;
    u.por = np[31:0];
    return u;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    longint f [6];
    cell_update_t want;
    if (rst) begin
      foreach (regs[i]) regs[i] = 0;
      regs[cpe_pkg::REG_SOLID_DENSITY] = ONE;
      regs[cpe_pkg::REG_TIME_SCALE] = ONE;
      updates_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        f[0] = flux_west;
        f[1] = flux_south;
        f[2] = flux_bottom;
        f[3] = flux_east;
        f[4] = flux_north;
        f[5] = flux_top;
        updates_due.insert(updates_due.size(),
                           predict_cell(f, concentration, porosity_in, dilatation_rate,
                                        well_cell));
      end
      if (out_valid && !out_stall) begin
        if (updates_due.size() == 0) begin
          report("unexpected word", new_source, 0);
        end else begin
          want = updates_due.pop_front();
          if (new_source !== want.src) report("new_source", new_source, want.src);
          if (source_written !== want.written)
            report("source_written", source_written, want.written);
          if (new_porosity !== want.por) report("new_porosity", new_porosity, want.por);
        end
      end
      if (wr_en && wr_index < 7) regs[wr_index] = longint'(signed'(wr_data));
    end
    pending = updates_due.size();
  end

endmodule

// File: dv/tb.sv
// top of the cell porosity erosion update testbench: clock, reset, register writes and cell
// stimulus under several idling patterns; depends on cpe_pkg, cpe_checker and the unit
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic signed [31:0] f [6];
    logic signed [31:0] conc, por, dil;
    logic               well;
  } cell_t;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [cpe_pkg::REG_IDX_W-1:0] wr_index;
  logic [cpe_pkg::WORD_W-1:0] wr_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] flux_west, flux_south, flux_bottom, flux_east, flux_north, flux_top;
  logic signed [31:0] concentration, porosity_in, dilatation_rate;
  logic well_cell, source_written;
  logic signed [31:0] new_source, new_porosity;
  int errors, pending, cycles;
  int send_idle, recv_stall;

  always #6 clk = ~clk;

  cell_porosity_erosion_update_unit i_dut (.*);
  cpe_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= ($urandom_range(99) < recv_stall);
    if (cycles > LIMIT) begin
      $display("cell_porosity_erosion_update_unit verification failed");
      $finish;
    end
  end

  task automatic put_reg(cpe_pkg::reg_idx_t idx, logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wr_en <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_cell(cell_t c);
    {flux_west, flux_south, flux_bottom} <= {c.f[0], c.f[1], c.f[2]};
    {flux_east, flux_north, flux_top} <= {c.f[3], c.f[4], c.f[5]};
    concentration <= c.conc;
    porosity_in <= c.por;
    dilatation_rate <= c.dil;
    well_cell <= c.well;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic cell_t rand_cell();
    cell_t c;
    if ($urandom_range(9) < 7) begin
      // plausible cells: modest fluxes, porosity between zero and one
      foreach (c.f[i]) c.f[i] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      c.conc = $urandom_range(0, 1 << 17);
      c.por = ($urandom_range(19) == 0) ? 0 : $urandom_range(0, 65536);
      c.dil = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      c.well = ($urandom_range(9) == 0);
    end else begin
      foreach (c.f[i]) c.f[i] = $urandom;
      c.conc = $urandom;
      c.por = $urandom;
      c.dil = $urandom;
      c.well = 1'($urandom_range(1));
    end
    return c;
  endfunction

  function automatic cell_t flat_cell(logic [31:0] fv, logic [31:0] cv, logic [31:0] pv,
                                      logic [31:0] dv, logic w);
    cell_t c;
    foreach (c.f[i]) c.f[i] = fv;
    c.conc = cv;
    c.por = pv;
    c.dil = dv;
    c.well = w;
    return c;
  endfunction

  task automatic load_config(int kind);
    logic [31:0] v;
    case (kind)
      0: begin
        put_reg(cpe_pkg::REG_SPEED_THRESHOLD, $urandom_range(0, 1 << 19));
        put_reg(cpe_pkg::REG_EROSION_RATE, $urandom_range(0, 1 << 16));
        put_reg(cpe_pkg::REG_DEPOSITION_RATE, $urandom_range(0, 1 << 16));
        put_reg(cpe_pkg::REG_SOLID_DENSITY, $urandom_range(1, 1 << 18));
        put_reg(cpe_pkg::REG_TIME_STEP, $urandom_range(0, 1 << 15));
        put_reg(cpe_pkg::REG_TIME_SCALE, $urandom_range(0, 1 << 17));
        put_reg(cpe_pkg::REG_WELL_POROSITY, $urandom_range(0, 65536));
      end
      1, 2: begin
        v = (kind == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        for (int r = 0; r < 7; r++) put_reg(cpe_pkg::reg_idx_t'(r), v);
      end
      default: begin
        for (int r = 0; r < 7; r++) put_reg(cpe_pkg::reg_idx_t'(r), $urandom);
        put_reg(cpe_pkg::REG_SOLID_DENSITY, 0);
      end
    endcase
  endtask

  initial begin
    cell_t c;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    in_valid <= 1'b0;
    send_idle = 0;
    recv_stall = 0;
    {flux_west, flux_south, flux_bottom, flux_east, flux_north, flux_top} <= '0;
    {concentration, porosity_in, dilatation_rate} <= '0;
    well_cell <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cells under a working setting
    load_config(0);
    put_reg(cpe_pkg::REG_SPEED_THRESHOLD, 32'h0002_0000);
    put_reg(cpe_pkg::REG_SOLID_DENSITY, 32'h0001_0000);
    wr_en <= 1'b0;
    send_cell(flat_cell(0, 0, 0, 0, 1'b0));
    send_cell(flat_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_cell(flat_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_cell(flat_cell(32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 1'b0));
    send_cell(flat_cell(32'hFFFF_0000, 32'h0001_0000, 0, 32'hFFFF_0000, 1'b0));
    send_cell(flat_cell(32'h0001_0000, 32'h0000_8000, 32'h0000_C000, 32'h0100_0000, 1'b0));
    send_cell(flat_cell(32'h0000_1000, 32'h0000_8000, 32'h0000_8000, 32'h0000_4000, 1'b0));
    send_cell(flat_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    send_cell(flat_cell(0, 0, 0, 0, 1'b1));
    // speed exactly at and just below the threshold: one flux of two, then one just under two
    c = flat_cell(0, 32'h0000_4000, 32'h0000_8000, 0, 1'b0);
    c.f[2] = 32'h0002_0000;
    send_cell(c);
    c.f[2] = 32'h0001_FFFF;
    send_cell(c);
    drain();
    load_config(3);
    wr_en <= 1'b0;
    send_cell(flat_cell(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0));
    send_cell(flat_cell(32'h8000_0000, 32'h0001_0000, 0, 32'h7FFF_FFFF, 1'b0));
    drain();

    for (int p = 0; p < 8; p++) begin
      load_config(p == 0 ? 0 : p % 4);
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 58; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 58; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      wr_en <= 1'b0;
      for (int n = 0; n < 170; n++) send_cell(rand_cell());
      drain();
    end

    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("cell_porosity_erosion_update_unit verification clean");
    end else begin
      $display("cell_porosity_erosion_update_unit verification failed");
    end
    $finish;
  end

endmodule
